@@ src/sorted_priority_queue_decrease_key_assert.svh @@
// Assertion macros used by the checker of the queue
`ifndef SORTED_PRIORITY_QUEUE_DECREASE_KEY_ASSERT_SVH
`define SORTED_PRIORITY_QUEUE_DECREASE_KEY_ASSERT_SVH

// Same-cycle implication, sampled on the rising edge, off during reset
`define SPQ_AST_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("queue check failed");

// Next-cycle implication, sampled on the rising edge, off during reset
`define SPQ_AST_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("queue check failed");

`endif

@@ src/spq_pkg.sv @@
package spq_pkg;

  // Default sizes
  localparam int DEPTH_DEF     = 16;
  localparam int ID_BITS_DEF   = 16;
  localparam int PRIO_BITS_DEF = 16;

  // Fixed field widths
  localparam int CMD_W    = 2;
  localparam int STATUS_W = 3;

  // Commands
  typedef enum logic [CMD_W-1:0] {
    CMD_INSERT  = 2'd0,
    CMD_POP     = 2'd1,
    CMD_UPGRADE = 2'd2,
    CMD_CLEAR   = 2'd3
  } cmd_t;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
  localparam logic [STATUS_W-1:0] ST_EMPTY       = 3'd1;
  localparam logic [STATUS_W-1:0] ST_MORE_URGENT = 3'd2;
  localparam logic [STATUS_W-1:0] ST_ABSENT      = 3'd3;
  localparam logic [STATUS_W-1:0] ST_FULL        = 3'd4;

  // What every cell does this cycle
  typedef enum logic [1:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_POP,
    CELL_REMOVE
  } cell_op_t;

  // Broadcast control to the row of cells
  typedef struct packed {
    cell_op_t op;
    logic     strict;   // place ahead of equal priorities
  } ctl_t;

  // Sequencer states
  typedef enum logic {
    S_IDLE,
    S_MOVE
  } state_t;

endpackage

@@ src/sorted_priority_queue_decrease_key.sv @@
// Timing: insert, pop, clear and a refused upgrade give their result in the cycle
// after acceptance; a successful upgrade goes through S_IDLE (locate and remove), then S_MOVE (re-place).
// Throughput: one word per cycle for insert, pop and clear while the result side does not stall;
// a successful upgrade holds off the next word in S_MOVE, set by the single shift of the cell row per cycle.
// Reset: synchronous active-low rst_n empties the queue and drops any pending
// result; cell contents are not reset and are never read before being written.
module sorted_priority_queue_decrease_key #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int ID_BITS   = spq_pkg::ID_BITS_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [spq_pkg::CMD_W-1:0]    in_cmd,
  input  logic [ID_BITS-1:0]           in_entry_id,
  input  logic [PRIO_BITS-1:0]         in_prio,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [spq_pkg::STATUS_W-1:0] out_status,
  output logic [ID_BITS-1:0]           out_popped_id,
  output logic [ID_BITS-1:0]           out_front_id,
  output logic [PRIO_BITS-1:0]         out_front_prio,
  output logic                         out_is_empty,
  output logic [CNT_W-1:0]             out_count
);

  spq_pkg::state_t state_r, state_nxt;
  spq_pkg::ctl_t   ctl;

  logic [CNT_W-1:0]     fill_r, fill_nxt;
  logic [ID_BITS-1:0]   hold_id_r;
  logic [PRIO_BITS-1:0] hold_prio_r;
  logic [ID_BITS-1:0]   key_id;
  logic [PRIO_BITS-1:0] key_prio;
  logic                 accept;
  logic                 load;

  logic                         out_valid_r;
  logic [spq_pkg::STATUS_W-1:0] out_status_r, status_nxt;
  logic [ID_BITS-1:0]           out_popped_r, popped_nxt;
  logic [ID_BITS-1:0]           out_front_id_r;
  logic [PRIO_BITS-1:0]         out_front_prio_r;
  logic                         out_is_empty_r;
  logic [CNT_W-1:0]             out_count_r;

  // Chains through the cell row; slot 0 is the front, outer slots tie off
  logic                 behind_c [0:DEPTH];
  logic                 found_c  [0:DEPTH];
  logic [ID_BITS-1:0]   id_sh    [0:DEPTH+1];
  logic [PRIO_BITS-1:0] prio_sh  [0:DEPTH+1];
  logic [PRIO_BITS-1:0] sel_prio [0:DEPTH-1];
  logic [ID_BITS-1:0]   id_nxt   [0:DEPTH-1];
  logic [PRIO_BITS-1:0] prio_nxt [0:DEPTH-1];
  logic [PRIO_BITS-1:0] match_prio;

  assign behind_c[0]    = 1'b0;
  assign found_c[0]     = 1'b0;
  assign id_sh[0]       = '0;
  assign prio_sh[0]     = '0;
  assign id_sh[DEPTH+1] = '0;
  assign prio_sh[DEPTH+1] = '0;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    spq_cell #(
      .ID_BITS  (ID_BITS),
      .PRIO_BITS(PRIO_BITS),
      .CNT_W    (CNT_W),
      .IDX      (i)
    ) u_cell (
      .clk        (clk),
      .ctl        (ctl),
      .fill       (fill_r),
      .key_id     (key_id),
      .key_prio   (key_prio),
      .left_behind(behind_c[i]),
      .left_found (found_c[i]),
      .left_id    (id_sh[i]),
      .left_prio  (prio_sh[i]),
      .right_id   (id_sh[i+2]),
      .right_prio (prio_sh[i+2]),
      .behind     (behind_c[i+1]),
      .found      (found_c[i+1]),
      .id         (id_sh[i+1]),
      .prio       (prio_sh[i+1]),
      .sel_prio   (sel_prio[i]),
      .id_nxt     (id_nxt[i]),
      .prio_nxt   (prio_nxt[i])
    );
  end

  // Gather the priority of the first matching entry
  always_comb begin
    match_prio = '0;
    for (int i = 0; i < DEPTH; i++) begin
      match_prio = match_prio | sel_prio[i];
    end
  end

  assign accept   = in_valid && in_ready;
  assign in_ready = (state_r == spq_pkg::S_IDLE) && (!out_valid_r || out_ready);

  // Sequence commands and drive the cell row
  always_comb begin
    state_nxt  = state_r;
    ctl.op     = spq_pkg::CELL_HOLD;
    ctl.strict = 1'b0;
    key_id     = in_entry_id;
    key_prio   = in_prio;
    fill_nxt   = fill_r;
    load       = 1'b0;
    status_nxt = spq_pkg::ST_OK;
    popped_nxt = '0;
    unique case (state_r)
      spq_pkg::S_IDLE: begin
        if (accept) begin
          unique case (spq_pkg::cmd_t'(in_cmd))
            spq_pkg::CMD_INSERT: begin
              load = 1'b1;
              if (fill_r == CNT_W'(DEPTH)) begin
                status_nxt = spq_pkg::ST_FULL;
              end else begin
                ctl.op   = spq_pkg::CELL_INSERT;
                fill_nxt = fill_r + CNT_W'(1);
              end
            end
            spq_pkg::CMD_POP: begin
              load = 1'b1;
              if (fill_r == '0) begin
                status_nxt = spq_pkg::ST_EMPTY;
              end else begin
                ctl.op     = spq_pkg::CELL_POP;
                popped_nxt = id_sh[1];
                fill_nxt   = fill_r - CNT_W'(1);
              end
            end
            spq_pkg::CMD_UPGRADE: begin
              if (fill_r == '0) begin
                load       = 1'b1;
                status_nxt = spq_pkg::ST_EMPTY;
              end else if (!found_c[DEPTH]) begin
                load       = 1'b1;
                status_nxt = spq_pkg::ST_ABSENT;
              end else if (match_prio < in_prio) begin
                load       = 1'b1;
                status_nxt = spq_pkg::ST_MORE_URGENT;
              end else begin
                ctl.op    = spq_pkg::CELL_REMOVE;
                fill_nxt  = fill_r - CNT_W'(1);
                state_nxt = spq_pkg::S_MOVE;
              end
            end
            spq_pkg::CMD_CLEAR: begin
              load     = 1'b1;
              fill_nxt = '0;
            end
            default: begin
            end
          endcase
        end
      end
      spq_pkg::S_MOVE: begin
        // re-place ahead of equal priorities
        ctl.op     = spq_pkg::CELL_INSERT;
        ctl.strict = 1'b1;
        key_id     = hold_id_r;
        key_prio   = hold_prio_r;
        fill_nxt   = fill_r + CNT_W'(1);
        load       = 1'b1;
        state_nxt  = spq_pkg::S_IDLE;
      end
      default: begin
        state_nxt = spq_pkg::S_IDLE;
      end
    endcase
  end

  // Advance control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spq_pkg::S_IDLE;
      fill_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      fill_r  <= fill_nxt;
      if (load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Hold the upgrade key and the result word
  always_ff @(posedge clk) begin
    if (accept) begin
      hold_id_r   <= in_entry_id;
      hold_prio_r <= in_prio;
    end
    if (load) begin
      out_status_r     <= status_nxt;
      out_popped_r     <= popped_nxt;
      out_front_id_r   <= (fill_nxt == '0) ? '0 : id_nxt[0];
      out_front_prio_r <= (fill_nxt == '0) ? '0 : prio_nxt[0];
      out_is_empty_r   <= (fill_nxt == '0);
      out_count_r      <= fill_nxt;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_status     = out_status_r;
  assign out_popped_id  = out_popped_r;
  assign out_front_id   = out_front_id_r;
  assign out_front_prio = out_front_prio_r;
  assign out_is_empty   = out_is_empty_r;
  assign out_count      = out_count_r;

endmodule

@@ src/spq_cell.sv @@
module spq_cell #(
  parameter int ID_BITS   = spq_pkg::ID_BITS_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
  parameter int CNT_W     = $clog2(spq_pkg::DEPTH_DEF + 1),
  parameter int IDX       = 0
) (
  input  logic                 clk,
  input  spq_pkg::ctl_t        ctl,
  input  logic [CNT_W-1:0]     fill,
  input  logic [ID_BITS-1:0]   key_id,
  input  logic [PRIO_BITS-1:0] key_prio,
  // neighbour towards the front
  input  logic                 left_behind,
  input  logic                 left_found,
  input  logic [ID_BITS-1:0]   left_id,
  input  logic [PRIO_BITS-1:0] left_prio,
  // neighbour towards the back
  input  logic [ID_BITS-1:0]   right_id,
  input  logic [PRIO_BITS-1:0] right_prio,
  // own state and chain outputs
  output logic                 behind,
  output logic                 found,
  output logic [ID_BITS-1:0]   id,
  output logic [PRIO_BITS-1:0] prio,
  output logic [PRIO_BITS-1:0] sel_prio,
  output logic [ID_BITS-1:0]   id_nxt,
  output logic [PRIO_BITS-1:0] prio_nxt
);

  logic [ID_BITS-1:0]   id_r;
  logic [PRIO_BITS-1:0] prio_r;
  logic                 occ;
  logic                 hit;
  logic                 first;

  // Compare against the key and extend the chains
  always_comb begin
    occ      = fill > CNT_W'(IDX);
    hit      = occ && (id_r == key_id);
    found    = left_found || hit;
    first    = hit && !left_found;
    behind   = !occ || (ctl.strict ? (prio_r >= key_prio) : (prio_r > key_prio));
    sel_prio = first ? prio_r : '0;
  end

  // Pick the next contents
  always_comb begin
    id_nxt   = id_r;
    prio_nxt = prio_r;
    unique case (ctl.op)
      spq_pkg::CELL_HOLD: begin
      end
      spq_pkg::CELL_INSERT: begin
        if (left_behind) begin
          id_nxt   = left_id;
          prio_nxt = left_prio;
        end else if (behind) begin
          id_nxt   = key_id;
          prio_nxt = key_prio;
        end
      end
      spq_pkg::CELL_POP: begin
        id_nxt   = right_id;
        prio_nxt = right_prio;
      end
      spq_pkg::CELL_REMOVE: begin
        if (found) begin
          id_nxt   = right_id;
          prio_nxt = right_prio;
        end
      end
      default: begin
      end
    endcase
  end

  // Hold the word
  always_ff @(posedge clk) begin
    id_r   <= id_nxt;
    prio_r <= prio_nxt;
  end

  assign id   = id_r;
  assign prio = prio_r;

endmodule

@@ src/spq_check.sv @@
`include "sorted_priority_queue_decrease_key_assert.svh"

module spq_check #(
  parameter int DEPTH     = spq_pkg::DEPTH_DEF,
  parameter int ID_BITS   = spq_pkg::ID_BITS_DEF,
  parameter int PRIO_BITS = spq_pkg::PRIO_BITS_DEF,
  parameter int CNT_W     = $clog2(DEPTH + 1)
) (
  input logic                         clk,
  input logic                         rst_n,
  input logic                         in_ready,
  input logic                         out_valid,
  input logic                         out_ready,
  input logic [spq_pkg::STATUS_W-1:0] out_status,
  input logic [ID_BITS-1:0]           out_popped_id,
  input logic [ID_BITS-1:0]           out_front_id,
  input logic [PRIO_BITS-1:0]         out_front_prio,
  input logic                         out_is_empty,
  input logic [CNT_W-1:0]             out_count
);

  logic stall;
  logic empty_word;
  logic err_word;
  logic [spq_pkg::STATUS_W+2*ID_BITS+PRIO_BITS+1+CNT_W-1:0] out_word;

  // Qualify the result word
  assign stall      = out_valid && !out_ready;
  assign empty_word = out_valid && out_is_empty;
  assign err_word   = out_valid && (out_status != spq_pkg::ST_OK);
  assign out_word   = {out_status, out_popped_id, out_front_id, out_front_prio,
                       out_is_empty, out_count};

  // A stalled result word holds
  `SPQ_AST_NEXT(a_out_hold, clk, rst_n, stall, out_valid && $stable(out_word))

  // A stalled result word blocks the input
  `SPQ_AST_NOW(a_in_block, clk, rst_n, stall, !in_ready)

  // Empty flag agrees with the count
  `SPQ_AST_NOW(a_empty_count, clk, rst_n, out_valid, out_is_empty == (out_count == '0))

  // An empty queue shows a zero front entry
  `SPQ_AST_NOW(a_empty_front, clk, rst_n, empty_word, out_front_id == '0 && out_front_prio == '0)

  // A failed command reports no popped id and a count within the depth
  `SPQ_AST_NOW(a_err_no_pop, clk, rst_n, err_word, out_popped_id == '0 && out_count <= CNT_W'(DEPTH))

endmodule

bind sorted_priority_queue_decrease_key spq_check #(
  .DEPTH    (DEPTH),
  .ID_BITS  (ID_BITS),
  .PRIO_BITS(PRIO_BITS),
  .CNT_W    (CNT_W)
) u_spq_check (.*);

@@ dv/tb_sorted_priority_queue_decrease_key.sv @@
module tb_sorted_priority_queue_decrease_key;
  import spq_pkg::*;

  localparam int DEPTH  = DEPTH_DEF;
  localparam int ID_W   = ID_BITS_DEF;
  localparam int PRIO_W = PRIO_BITS_DEF;
  localparam int CNT_W  = $clog2(DEPTH + 1);

  typedef logic [ID_W-1:0]   id_t;
  typedef logic [PRIO_W-1:0] prio_t;

  // One result word as the queue reports it
  typedef struct packed {
    logic [STATUS_W-1:0] status;
    id_t                 popped_id;
    id_t                 front_id;
    prio_t               front_prio;
    logic                is_empty;
    logic [CNT_W-1:0]    count;
  } queue_report_t;

  logic                clk;
  logic                rst_n;
  logic                in_valid;
  logic                in_ready;
  logic [CMD_W-1:0]    in_cmd;
  id_t                 in_entry_id;
  prio_t               in_prio;
  logic                out_valid;
  logic                out_ready;
  logic [STATUS_W-1:0] out_status;
  id_t                 out_popped_id;
  id_t                 out_front_id;
  prio_t               out_front_prio;
  logic                out_is_empty;
  logic [CNT_W-1:0]    out_count;

  sorted_priority_queue_decrease_key uut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_cmd         (in_cmd),
    .in_entry_id    (in_entry_id),
    .in_prio        (in_prio),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_status     (out_status),
    .out_popped_id  (out_popped_id),
    .out_front_id   (out_front_id),
    .out_front_prio (out_front_prio),
    .out_is_empty   (out_is_empty),
    .out_count      (out_count)
  );

  // Shadow copy of the sorted slots, front at index 0
  id_t   shadow_ids[DEPTH];
  prio_t shadow_prios[DEPTH];
  int    shadow_fill;

  queue_report_t awaited_reports[$];
  int            mismatches;
  int            reports_checked;
  int            cmd_tally[4];
  int            status_tally[5];
  bit            word_held;
  bit            steady_in;
  bit            steady_out;
  int            stall_left;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #4_000_000;
    $display("tb_sorted_priority_queue_decrease_key: done, errors");
    $finish;
  end

  // Mostly short gaps, now and then a long one
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 92) return $urandom_range(1, 3);
    return $urandom_range(4, 24);
  endfunction

  // Open a slot at pos and write the entry there
  function automatic void shadow_place(int pos, id_t id, prio_t pr);
    int k;
    for (k = shadow_fill; k > pos; k--) begin
      shadow_ids[k]   = shadow_ids[k-1];
      shadow_prios[k] = shadow_prios[k-1];
    end
    shadow_ids[pos]   = id;
    shadow_prios[pos] = pr;
    shadow_fill++;
  endfunction

  // Close the slot at pos
  function automatic void shadow_remove(int pos);
    int k;
    for (k = pos; k + 1 < shadow_fill; k++) begin
      shadow_ids[k]   = shadow_ids[k+1];
      shadow_prios[k] = shadow_prios[k+1];
    end
    shadow_fill--;
  endfunction

  // Apply one command to the shadow queue and return the report it should give
  function automatic queue_report_t predict_report(cmd_t c, id_t id, prio_t pr);
    queue_report_t rep;
    int            pos;
    int            k;
    rep        = '0;
    rep.status = ST_OK;
    case (c)
      CMD_INSERT: begin
        if (shadow_fill >= DEPTH) begin
          rep.status = ST_FULL;
        end else begin
          // behind every entry of equal or smaller priority
          pos = 0;
          while (pos < shadow_fill && shadow_prios[pos] <= pr) pos++;
          shadow_place(pos, id, pr);
        end
      end
      CMD_POP: begin
        if (shadow_fill == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          rep.popped_id = shadow_ids[0];
          shadow_remove(0);
        end
      end
      CMD_UPGRADE: begin
        if (shadow_fill == 0) begin
          rep.status = ST_EMPTY;
        end else begin
          k = 0;
          while (k < shadow_fill && shadow_ids[k] != id) k++;
          if (k == shadow_fill) begin
            rep.status = ST_ABSENT;
          end else if (shadow_prios[k] < pr) begin
            rep.status = ST_MORE_URGENT;
          end else begin
            // ahead of every entry of equal or larger priority
            shadow_remove(k);
            pos = 0;
            while (pos < shadow_fill && shadow_prios[pos] < pr) pos++;
            shadow_place(pos, id, pr);
          end
        end
      end
      default: shadow_fill = 0;
    endcase
    if (shadow_fill != 0) begin
      rep.front_id   = shadow_ids[0];
      rep.front_prio = shadow_prios[0];
    end
    rep.is_empty = (shadow_fill == 0);
    rep.count    = CNT_W'(shadow_fill);
    return rep;
  endfunction

  // Lower valid only if a word is still held on the port
  task automatic drop_valid();
    if (word_held) begin
      in_valid  <= 1'b0;
      word_held = 1'b0;
    end
  endtask

  // Offer one word, hold it until taken, then predict its report
  task automatic send_word(cmd_t c, id_t id, prio_t pr);
    int            gap;
    queue_report_t rep;
    gap = steady_in ? 0 : pick_gap();
    if (gap > 0) begin
      drop_valid();
      repeat (gap) @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_cmd      <= c;
    in_entry_id <= id;
    in_prio     <= pr;
    word_held   = 1'b1;
    do @(posedge clk); while (!in_ready);
    rep = predict_report(c, id, pr);
    awaited_reports.push_back(rep);
    cmd_tally[c]++;
    status_tally[rep.status]++;
  endtask

  // Hold off the sender until every report is in
  task automatic wait_all_reports();
    drop_valid();
    @(posedge clk);
    while (awaited_reports.size() != 0) @(posedge clk);
  endtask

  // Result side: random stalls, with stretches of steady acceptance
  always @(posedge clk) begin
    if (steady_out) begin
      out_ready <= 1'b1;
    end else if (stall_left > 0) begin
      out_ready <= 1'b0;
      stall_left--;
    end else begin
      out_ready <= 1'b1;
      if ($urandom_range(0, 99) < 30) stall_left = pick_gap();
    end
  end

  // Compare each accepted report with the oldest prediction
  always @(posedge clk) begin
    queue_report_t want;
    if (rst_n && out_valid && out_ready) begin
      if (awaited_reports.size() == 0) begin
        mismatches++;
        $error("report word with none awaited: status %0d count %0d", out_status, out_count);
      end else begin
        want = awaited_reports.pop_front();
        reports_checked++;
        if (out_status !== want.status) begin
          mismatches++;
          $error("status: expected %0d, got %0d", want.status, out_status);
        end
        if (out_popped_id !== want.popped_id) begin
          mismatches++;
          $error("popped_id: expected %h, got %h", want.popped_id, out_popped_id);
        end
        if (out_front_id !== want.front_id) begin
          mismatches++;
          $error("front_id: expected %h, got %h", want.front_id, out_front_id);
        end
        if (out_front_prio !== want.front_prio) begin
          mismatches++;
          $error("front_prio: expected %h, got %h", want.front_prio, out_front_prio);
        end
        if (out_is_empty !== want.is_empty) begin
          mismatches++;
          $error("is_empty: expected %0d, got %0d", want.is_empty, out_is_empty);
        end
        if (out_count !== want.count) begin
          mismatches++;
          $error("count: expected %0d, got %0d", want.count, out_count);
        end
      end
    end
  end

  // Pop, upgrade and clear with nothing held
  task automatic test_empty_commands();
    send_word(CMD_POP, '0, '0);
    send_word(CMD_UPGRADE, '1, '0);
    send_word(CMD_CLEAR, '0, '0);
    wait_all_reports();
  endtask

  // Fill every slot with extreme values, ties and a repeated id, then overfill
  task automatic test_fill_to_capacity();
    id_t   ids[DEPTH] = '{16'h0000, 16'hFFFF, 16'h1234, 16'hA5A5, 16'h5A5A, 16'h0001,
                          16'h1234, 16'h8000, 16'h7FFF, 16'h00FF, 16'hFF00, 16'h0F0F,
                          16'hF0F0, 16'h3333, 16'hCCCC, 16'h5555};
    prio_t prios[DEPTH] = '{16'h0000, 16'hFFFF, 16'h0010, 16'h0010, 16'h8000, 16'h0010,
                            16'h0200, 16'h7FFF, 16'h0001, 16'hFF00, 16'h00FF, 16'h0010,
                            16'hFFFF, 16'h0000, 16'h4000, 16'h0020};
    int    i;
    for (i = 0; i < DEPTH; i++) send_word(CMD_INSERT, ids[i], prios[i]);
    send_word(CMD_INSERT, 16'hDEAD, 16'h0005);
    wait_all_reports();
  endtask

  // Absent id, larger priority, equal priority, repeated id, tail to front
  task automatic test_upgrade_cases();
    send_word(CMD_UPGRADE, 16'hBEEF, 16'h0000);
    send_word(CMD_UPGRADE, 16'hA5A5, 16'h0011);
    send_word(CMD_UPGRADE, 16'hA5A5, 16'h0010);
    send_word(CMD_UPGRADE, 16'h1234, 16'h0000);
    send_word(CMD_UPGRADE, 16'hFFFF, 16'h0000);
    wait_all_reports();
  endtask

  // Pop from a full queue, clear it, pop once more on empty
  task automatic test_pop_and_clear();
    send_word(CMD_POP, 16'hFFFF, 16'hFFFF);
    send_word(CMD_POP, '0, '0);
    send_word(CMD_CLEAR, 16'hFFFF, 16'hFFFF);
    send_word(CMD_POP, '0, '0);
    wait_all_reports();
  endtask

  // Random traffic steered towards a fill target that moves every segment
  task automatic test_random_traffic(int n_words);
    int    i;
    int    r;
    int    k;
    int    ins_w;
    int    target;
    cmd_t  c;
    id_t   id;
    prio_t pr;
    target = DEPTH / 2;
    for (i = 0; i < n_words; i++) begin
      if (i % 100 == 0) begin
        r = $urandom_range(0, 3);
        target     = (r == 0) ? 0 : (r == 1) ? DEPTH : $urandom_range(0, DEPTH);
        steady_in  = ($urandom_range(0, 4) == 0);
        steady_out = ($urandom_range(0, 4) == 0);
        if ($urandom_range(0, 3) == 0) wait_all_reports();
      end
      r     = $urandom_range(0, 99);
      ins_w = (shadow_fill < target) ? 60 : 25;
      if (r < 2) c = CMD_CLEAR;
      else if (r < 2 + ins_w) c = CMD_INSERT;
      else if (r < 2 + ins_w + (98 - ins_w) / 2) c = CMD_POP;
      else c = CMD_UPGRADE;
      // noise in the unused fields by default
      id = id_t'($urandom);
      pr = prio_t'($urandom);
      if (c == CMD_INSERT) begin
        if ($urandom_range(0, 2) == 0) id = id_t'($urandom_range(0, 7));
        if ($urandom_range(0, 1) == 0) pr = prio_t'($urandom_range(0, 15));
      end else if (c == CMD_UPGRADE && shadow_fill > 0 && $urandom_range(0, 9) < 8) begin
        // aim at a held entry: lower, equal or larger priority
        k  = $urandom_range(0, shadow_fill - 1);
        id = shadow_ids[k];
        r  = $urandom_range(0, 99);
        if (r < 55) pr = prio_t'($urandom_range(0, shadow_prios[k]));
        else if (r < 75 || shadow_prios[k] == {PRIO_W{1'b1}}) pr = shadow_prios[k];
        else pr = prio_t'($urandom_range(shadow_prios[k] + 1, {PRIO_W{1'b1}}));
      end
      send_word(c, id, pr);
    end
  endtask

  initial begin
    in_valid    <= 1'b0;
    in_cmd      <= CMD_INSERT;
    in_entry_id <= '0;
    in_prio     <= '0;
    out_ready   <= 1'b0;
    rst_n       <= 1'b0;
    shadow_fill     = 0;
    mismatches      = 0;
    reports_checked = 0;
    word_held       = 1'b0;
    steady_in       = 1'b0;
    steady_out      = 1'b0;
    stall_left      = 0;
    foreach (cmd_tally[i]) cmd_tally[i] = 0;
    foreach (status_tally[i]) status_tally[i] = 0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_empty_commands();
    test_fill_to_capacity();
    test_upgrade_cases();
    test_pop_and_clear();
    test_random_traffic(1380);

    // drain, then keep watching for any stray report
    wait_all_reports();
    repeat (8) @(posedge clk);

    $display("Sent %0d insert, %0d pop, %0d upgrade, %0d clear words; %0d reports compared",
             cmd_tally[CMD_INSERT], cmd_tally[CMD_POP], cmd_tally[CMD_UPGRADE],
             cmd_tally[CMD_CLEAR], reports_checked);
    $display("Outcomes: ok %0d, empty %0d, already urgent %0d, absent %0d, full %0d",
             status_tally[ST_OK], status_tally[ST_EMPTY], status_tally[ST_MORE_URGENT],
             status_tally[ST_ABSENT], status_tally[ST_FULL]);
    if (mismatches == 0) begin
      $display("tb_sorted_priority_queue_decrease_key: done, clean");
    end else begin
      $display("tb_sorted_priority_queue_decrease_key: done, errors");
    end
    $finish;
  end

endmodule

@@ files.f @@
+incdir+src
src/spq_pkg.sv
src/spq_cell.sv
src/sorted_priority_queue_decrease_key.sv
src/spq_check.sv
dv/tb_sorted_priority_queue_decrease_key.sv
